FILE: design/mfl_pkg.sv
// ----------------------------------------------------------------------------
// mfl_pkg
// Shared types and constants of the magazine free list: request and result
// item layouts, status and request codes, and configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package mfl_pkg;

  // Field widths fixed by the item layout
  localparam int ELEM_W  = 32;
  localparam int LANE_IN_W = 2;
  localparam int CNT_W   = 11;
  localparam int PADDR_W = 3;

  // Request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_PUSH_OK      = 2'd0;
  localparam logic [1:0] ST_PUSH_REFUSED = 2'd1;
  localparam logic [1:0] ST_POP_OK       = 2'd2;
  localparam logic [1:0] ST_EMPTY        = 2'd3;

  // Register map: word index taken from paddr[2]
  localparam logic REG_MAX_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] MAX_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic                 req_type;
    logic [LANE_IN_W-1:0] lane;
    logic [ELEM_W-1:0]    element_in;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ELEM_W-1:0] element_out;
  } rsp_t;

endpackage

`default_nettype wire

FILE: design/mfl_ram.sv
// ----------------------------------------------------------------------------
// mfl_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/mfl_lane_table.sv
// ----------------------------------------------------------------------------
// mfl_lane_table
// Per-lane magazine id and fill count, held in a RAM. A per-lane valid bit
// makes an entry never written since reset read as its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module mfl_lane_table #(
  parameter int LANES  = 4,
  parameter int ID_W   = 7,
  parameter int FILL_W = 5
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      rd_en,
  input  wire logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] rd_lane,
  output logic      [ID_W-1:0]                           rd_id,
  output logic      [FILL_W-1:0]                         rd_fill,
  input  wire logic                                      wr_en,
  input  wire logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] wr_lane,
  input  wire logic [ID_W-1:0]                           wr_id,
  input  wire logic [FILL_W-1:0]                         wr_fill
);

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [LANES-1:0]       written;
  logic                   rd_hit;
  logic [LANE_W-1:0]      rd_lane_q;
  logic [ID_W+FILL_W-1:0] ram_rd_data;

  mfl_ram #(
    .DEPTH (LANES),
    .WIDTH (ID_W + FILL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_lane),
    .wr_data ({wr_id, wr_fill}),
    .rd_en   (rd_en),
    .rd_addr (rd_lane),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_lane] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hit    <= written[rd_lane];
      rd_lane_q <= rd_lane;
    end
  end

  // Unwritten lane i holds id i with an empty magazine
  assign rd_id   = rd_hit ? ram_rd_data[ID_W+FILL_W-1:FILL_W] : ID_W'(rd_lane_q);
  assign rd_fill = rd_hit ? ram_rd_data[FILL_W-1:0] : '0;

endmodule

`default_nettype wire

FILE: design/magazine_free_list.sv
// ----------------------------------------------------------------------------
// magazine_free_list
// Magazine-based free-element cache with per-lane magazines, a shared stack
// of full magazines and a stack of spare magazine ids.
// ----------------------------------------------------------------------------
// Each lane owns one magazine, a LIFO of MAG_SIZE element handles. A push
// returns an element to the lane's magazine; a pop takes the most recent one.
// When a push finds its magazine full, the magazine moves onto the shared
// full stack and the lane takes a fresh id from the spare stack, provided the
// full stack has room, a spare id is left and the shared element count plus
// one magazine stays below max_count (register at byte address 0, reset
// 1024); otherwise the push is refused. When a pop finds its magazine empty,
// the lane gives its id back to the spare stack and takes the top full
// magazine, or reports an empty pool. Every request gives exactly one result
// item. One item is worked on at a time. Each first reads the lane table; a
// pop from a non-empty magazine then reads the element store, a push that
// swaps magazines the spare stack, and a pop that swaps magazines the full
// stack and then the element store. These registered reads sit in series
// on the magazine-swap paths. The next item is accepted only once the result
// is loaded into the output register, where it waits while the next item is
// accepted. No clearing pass is needed after reset: the lane table uses
// per-lane valid bits, and the spare stack marks its untouched entries with
// a low-water count. The element store holds ELEM_WIDTH bits per handle.
// ----------------------------------------------------------------------------
`default_nettype none

module magazine_free_list
  import mfl_pkg::*;
#(
  parameter int LANES      = 4,
  parameter int MAG_SIZE   = 16,
  parameter int MAX_FULL   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire req_t               req,
  // result channel
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rsp_t                    rsp,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int NUM_IDS   = LANES + MAX_FULL;
  localparam int NUM_SLOTS = NUM_IDS * MAG_SIZE;
  localparam int ID_W      = $clog2(NUM_IDS);
  localparam int FILL_W    = $clog2(MAG_SIZE + 1);
  localparam int POS_W     = $clog2(MAG_SIZE);
  localparam int SLOT_AW   = $clog2(NUM_SLOTS);
  localparam int STK_AW    = (MAX_FULL > 1) ? $clog2(MAX_FULL) : 1;
  localparam int DEP_W     = $clog2(MAX_FULL + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_LANE      = 3'd1;
  localparam logic [2:0] S_SWAP_PUSH = 3'd2;
  localparam logic [2:0] S_SWAP_POP  = 3'd3;
  localparam logic [2:0] S_SLOT      = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [ID_W-1:0]  id,
                                                   input logic [POS_W-1:0] pos);
    slot_addr = SLOT_AW'(id) * SLOT_AW'(MAG_SIZE) + SLOT_AW'(pos);
  endfunction

  // Registers
  logic [2:0]          state, state_next;
  logic                req_kind;
  logic [ELEM_W-1:0]   req_elem;
  logic [LANE_W-1:0]   lane_q;
  logic [1:0]          res_status, res_status_next;
  logic [ELEM_W-1:0]   res_elem, res_elem_next;
  logic [DEP_W-1:0]    full_depth, full_depth_next;
  logic [DEP_W-1:0]    spare_depth, spare_depth_next;
  logic [DEP_W-1:0]    spare_min, spare_min_next;
  logic                spare_fresh, spare_fresh_next;
  logic [CNT_W-1:0]    shared_count, shared_count_next;
  logic [CNT_W-1:0]    max_count;

  // Lane table
  logic [1:0]          lane_tmp;
  logic [LANE_W-1:0]   lane_idx;
  logic                lt_rd_en;
  logic [ID_W-1:0]     lt_id;
  logic [FILL_W-1:0]   lt_fill;
  logic                lt_wr_en;
  logic [ID_W-1:0]     lt_wr_id;
  logic [FILL_W-1:0]   lt_wr_fill;

  // Element store
  logic                slot_wr_en, slot_rd_en;
  logic [SLOT_AW-1:0]  slot_wr_addr, slot_rd_addr;
  logic [ELEM_WIDTH-1:0] slot_rd_data;

  // Id stacks
  logic                full_wr_en, full_rd_en;
  logic [STK_AW-1:0]   full_wr_addr, full_rd_addr;
  logic [ID_W-1:0]     full_rd_data;
  logic                spare_wr_en, spare_rd_en;
  logic [STK_AW-1:0]   spare_wr_addr, spare_rd_addr;
  logic [ID_W-1:0]     spare_rd_data;

  logic                accept;
  logic                rsp_free;
  logic                cfg_write;
  logic [CNT_W:0]      shared_plus;
  logic                refuse;
  logic [DEP_W-1:0]    full_top, spare_top;
  logic [FILL_W-1:0]   fill_dec;
  logic [ID_W-1:0]     fresh_id;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Fold the lane number into the lane range
  always_comb begin
    lane_tmp = req.lane;
    for (int k = 0; k < 3; k++) begin
      if (int'(lane_tmp) >= LANES) begin
        lane_tmp = lane_tmp - 2'(LANES);
      end
    end
    lane_idx = LANE_W'(lane_tmp);
  end

  mfl_lane_table #(
    .LANES  (LANES),
    .ID_W   (ID_W),
    .FILL_W (FILL_W)
  ) u_lane_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (lt_rd_en),
    .rd_lane (lane_idx),
    .rd_id   (lt_id),
    .rd_fill (lt_fill),
    .wr_en   (lt_wr_en),
    .wr_lane (lane_q),
    .wr_id   (lt_wr_id),
    .wr_fill (lt_wr_fill)
  );

  mfl_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (ELEM_WIDTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (ELEM_WIDTH'(req_elem)),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data)
  );

  mfl_ram #(
    .DEPTH (MAX_FULL),
    .WIDTH (ID_W)
  ) u_full_stack (
    .clk     (clk),
    .wr_en   (full_wr_en),
    .wr_addr (full_wr_addr),
    .wr_data (lt_id),
    .rd_en   (full_rd_en),
    .rd_addr (full_rd_addr),
    .rd_data (full_rd_data)
  );

  mfl_ram #(
    .DEPTH (MAX_FULL),
    .WIDTH (ID_W)
  ) u_spare_stack (
    .clk     (clk),
    .wr_en   (spare_wr_en),
    .wr_addr (spare_wr_addr),
    .wr_data (lt_id),
    .rd_en   (spare_rd_en),
    .rd_addr (spare_rd_addr),
    .rd_data (spare_rd_data)
  );

  assign shared_plus = {1'b0, shared_count} + (CNT_W + 1)'(MAG_SIZE);
  assign refuse      = (shared_plus >= {1'b0, max_count}) ||
                       (full_depth >= DEP_W'(MAX_FULL)) ||
                       (spare_depth == '0);
  assign full_top    = full_depth - DEP_W'(1);
  assign spare_top   = spare_depth - DEP_W'(1);
  assign fill_dec    = lt_fill - FILL_W'(1);
  // Spare entries below the low-water mark still hold their reset ids
  assign fresh_id    = ID_W'(LANES) + ID_W'(spare_top);

  always_comb begin
    state_next        = state;
    res_status_next   = res_status;
    res_elem_next     = res_elem;
    full_depth_next   = full_depth;
    spare_depth_next  = spare_depth;
    spare_min_next    = spare_min;
    spare_fresh_next  = spare_fresh;
    shared_count_next = shared_count;
    lt_rd_en          = 1'b0;
    lt_wr_en          = 1'b0;
    lt_wr_id          = lt_id;
    lt_wr_fill        = lt_fill;
    slot_wr_en        = 1'b0;
    slot_wr_addr      = '0;
    slot_rd_en        = 1'b0;
    slot_rd_addr      = '0;
    full_wr_en        = 1'b0;
    full_wr_addr      = full_depth[STK_AW-1:0];
    full_rd_en        = 1'b0;
    full_rd_addr      = full_top[STK_AW-1:0];
    spare_wr_en       = 1'b0;
    spare_wr_addr     = spare_depth[STK_AW-1:0];
    spare_rd_en       = 1'b0;
    spare_rd_addr     = spare_top[STK_AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          lt_rd_en   = 1'b1;
          state_next = S_LANE;
        end
      end

      S_LANE: begin
        res_elem_next = '0;
        if (req_kind == REQ_PUSH) begin
          priority if (lt_fill != FILL_W'(MAG_SIZE)) begin
            // Room in the lane magazine
            slot_wr_en      = 1'b1;
            slot_wr_addr    = slot_addr(lt_id, lt_fill[POS_W-1:0]);
            lt_wr_en        = 1'b1;
            lt_wr_fill      = lt_fill + FILL_W'(1);
            res_status_next = ST_PUSH_OK;
            state_next      = S_DONE;
          end else if (refuse) begin
            res_status_next = ST_PUSH_REFUSED;
            state_next      = S_DONE;
          end else begin
            // Retire the full magazine, fetch a spare id
            full_wr_en        = 1'b1;
            full_depth_next   = full_depth + DEP_W'(1);
            shared_count_next = shared_count + CNT_W'(MAG_SIZE);
            spare_rd_en       = 1'b1;
            spare_fresh_next  = (spare_depth == spare_min);
            state_next        = S_SWAP_PUSH;
          end
        end else begin
          priority if (lt_fill != '0) begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = slot_addr(lt_id, fill_dec[POS_W-1:0]);
            lt_wr_en     = 1'b1;
            lt_wr_fill   = fill_dec;
            state_next   = S_SLOT;
          end else if ((full_depth == '0) || (spare_depth >= DEP_W'(MAX_FULL))) begin
            res_status_next = ST_EMPTY;
            state_next      = S_DONE;
          end else begin
            // Hand back the empty magazine, fetch the top full one
            spare_wr_en       = 1'b1;
            spare_depth_next  = spare_depth + DEP_W'(1);
            full_rd_en        = 1'b1;
            full_depth_next   = full_top;
            shared_count_next = shared_count - CNT_W'(MAG_SIZE);
            state_next        = S_SWAP_POP;
          end
        end
      end

      S_SWAP_PUSH: begin
        lt_wr_en         = 1'b1;
        lt_wr_id         = spare_fresh ? fresh_id : spare_rd_data;
        lt_wr_fill       = FILL_W'(1);
        slot_wr_en       = 1'b1;
        slot_wr_addr     = slot_addr(lt_wr_id, '0);
        spare_depth_next = spare_top;
        if (spare_fresh) begin
          spare_min_next = spare_top;
        end
        res_status_next  = ST_PUSH_OK;
        state_next       = S_DONE;
      end

      S_SWAP_POP: begin
        lt_wr_en     = 1'b1;
        lt_wr_id     = full_rd_data;
        lt_wr_fill   = FILL_W'(MAG_SIZE - 1);
        slot_rd_en   = 1'b1;
        slot_rd_addr = slot_addr(full_rd_data, POS_W'(MAG_SIZE - 1));
        state_next   = S_SLOT;
      end

      S_SLOT: begin
        res_status_next = ST_POP_OK;
        res_elem_next   = ELEM_W'(slot_rd_data);
        state_next      = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register can take the result
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      full_depth   <= '0;
      spare_depth  <= DEP_W'(MAX_FULL);
      spare_min    <= DEP_W'(MAX_FULL);
      spare_fresh  <= 1'b0;
      shared_count <= '0;
    end else begin
      state        <= state_next;
      full_depth   <= full_depth_next;
      spare_depth  <= spare_depth_next;
      spare_min    <= spare_min_next;
      spare_fresh  <= spare_fresh_next;
      shared_count <= shared_count_next;
    end
  end

  // Capture the request payload and register the working result
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= req.req_type;
      req_elem <= req.element_in;
      lane_q   <= lane_idx;
    end
    res_status <= res_status_next;
    res_elem   <= res_elem_next;
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && rsp_free) begin
      rsp.status      <= res_status;
      rsp.element_out <= res_elem;
    end
  end

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= MAX_COUNT_RESET;
    end else if (cfg_write) begin
      max_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_COUNT) ? 32'(max_count) : '0;

endmodule

`default_nettype wire

FILE: design/mfl_checker.sv
// ----------------------------------------------------------------------------
// mfl_checker
// Port-level checks of the magazine free list: result hold under stall,
// result payload rules and item accounting between the two channels.
// ----------------------------------------------------------------------------
`default_nettype none

module mfl_checker
  import mfl_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  logic [1:0] pending;

  // Track items accepted whose result is not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && !req_stall) - 2'(rsp_valid && !rsp_stall);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_POP_OK) |-> (rsp.element_out == '0))
    else $error("element given on a result that is not a served pop");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pending != 2'd0))
    else $error("result without an accepted item");

  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items in flight");

endmodule

bind magazine_free_list mfl_checker u_mfl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
